[sv/wsfd_pkg.sv]
`timescale 1ns / 1ps

package wsfd_pkg;

  // Header field codes
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended length / mask key byte counts, minus one
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;
  localparam logic [2:0] KEY_CNT   = 3'd3;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_PING  = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    kind_e      frame_kind;
    logic       last;
    logic       status;
  } res_t;

endpackage

[sv/wsfd_if.sv]
`timescale 1ns / 1ps

interface wsfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_data;
  logic [1:0] frame_kind;
  logic       last;
  logic       status;
  modport source (output valid, output data_byte, output has_data, output frame_kind,
                  output last, output status, input ready);
  modport sink   (input valid, input data_byte, input has_data, input frame_kind,
                  input last, input status, output ready);
endinterface

interface wsfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_payload;
  modport source (output valid, output max_payload, input ready);
  modport sink   (input valid, input max_payload, output ready);
endinterface

[sv/wsfd_parse.sv]
`timescale 1ns / 1ps

module wsfd_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  wsfd_rx_if.sink            rx,
  wsfd_cfg_if.sink           cfg,
  input  logic               space_i,
  output logic               push_valid_o,
  output wsfd_pkg::res_t     push_res_o
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASKKEY = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  phase_e      ph_q, ph_d;
  logic [3:0]  op_q, op_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;     // length, then bytes still to come in payload
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  pos_q, pos_d;
  logic        link_q, link_d;
  logic [31:0] max_q;

  logic           acc;
  logic [7:0]     b;
  logic           do_known, do_start, do_finish;
  logic [63:0]    known_len, start_len;
  logic [7:0]     key_byte;
  logic           is_last;
  logic           res_v;
  wsfd_pkg::res_t res;

  assign rx.ready  = space_i;
  assign cfg.ready = 1'b1;
  assign acc       = rx.valid && space_i;
  assign b         = rx.rx_byte;

  always_comb begin
    unique case (pos_q)
      2'd0: key_byte = key_q[31:24];
      2'd1: key_byte = key_q[23:16];
      2'd2: key_byte = key_q[15:8];
      2'd3: key_byte = key_q[7:0];
    endcase
  end

  assign is_last = (len_q[31:0] == 32'd1);

  always_comb begin
    ph_d      = ph_q;
    op_d      = op_q;
    mask_d    = mask_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    pos_d     = pos_q;
    link_d    = link_q;
    do_known  = 1'b0;
    do_start  = 1'b0;
    do_finish = 1'b0;
    known_len = '0;
    start_len = '0;
    res_v     = 1'b0;
    res       = '0;

    if (acc && link_q) begin
      unique case (ph_q)
        PH_HDR0: begin
          op_d = b[3:0];
          ph_d = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d = b[7];
          len_d  = '0;
          if (b[6:0] == wsfd_pkg::LEN_EXT16) begin
            cnt_d = wsfd_pkg::EXT16_CNT;
            ph_d  = PH_EXTLEN;
          end else if (b[6:0] == wsfd_pkg::LEN_EXT64) begin
            cnt_d = wsfd_pkg::EXT64_CNT;
            ph_d  = PH_EXTLEN;
          end else begin
            do_known  = 1'b1;
            known_len = {57'd0, b[6:0]};
          end
        end
        PH_EXTLEN: begin
          len_d = {len_q[55:0], b};
          if (cnt_q == 3'd0) begin
            do_known  = 1'b1;
            known_len = {len_q[55:0], b};
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
        PH_MASKKEY: begin
          key_d = {key_q[23:0], b};
          if (cnt_q == 3'd0) begin
            do_start  = 1'b1;
            start_len = len_q;
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          pos_d = pos_q + 2'd1;
          len_d = {32'd0, len_q[31:0] - 32'd1};
          if (op_q == wsfd_pkg::OP_TEXT || op_q == wsfd_pkg::OP_PING) begin
            res_v          = 1'b1;
            res.data_byte  = b ^ key_byte;
            res.has_data   = 1'b1;
            res.frame_kind = (op_q == wsfd_pkg::OP_PING) ? wsfd_pkg::KIND_PING
                                                         : wsfd_pkg::KIND_TEXT;
            res.last       = is_last;
            if (is_last) begin
              ph_d = PH_HDR0;
            end
          end else if (is_last) begin
            do_finish = 1'b1;
          end
        end
        default: begin
          ph_d = PH_HDR0;
        end
      endcase

      // full length known: limit check, then mask key, payload or (when empty) frame end
      if (do_known) begin
        len_d = known_len;
        key_d = '0;
        if ((|known_len[63:32]) || (known_len[31:0] > max_q)) begin
          link_d         = 1'b0;
          res_v          = 1'b1;
          res.frame_kind = wsfd_pkg::KIND_CLOSE;
          res.last       = 1'b1;
          res.status     = 1'b1;
        end else if (mask_d) begin
          cnt_d = wsfd_pkg::KEY_CNT;
          ph_d  = PH_MASKKEY;
        end else begin
          do_start  = 1'b1;
          start_len = known_len;
        end
      end

      if (do_start) begin
        pos_d = 2'd0;
        if (start_len == 64'd0) begin
          do_finish = 1'b1;
        end else begin
          ph_d = PH_PAYLOAD;
        end
      end

      if (do_finish) begin
        ph_d = PH_HDR0;
        if (op_q == wsfd_pkg::OP_TEXT) begin
          res_v          = 1'b1;
          res.frame_kind = wsfd_pkg::KIND_TEXT;
          res.last       = 1'b1;
        end else if (op_q == wsfd_pkg::OP_PING) begin
          res_v          = 1'b1;
          res.frame_kind = wsfd_pkg::KIND_PING;
          res.last       = 1'b1;
        end else if (op_q == wsfd_pkg::OP_CLOSE) begin
          link_d         = 1'b0;
          res_v          = 1'b1;
          res.frame_kind = wsfd_pkg::KIND_CLOSE;
          res.last       = 1'b1;
        end
      end
    end
  end

  assign push_valid_o = res_v;
  assign push_res_o   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_HDR0;
      op_q   <= '0;
      mask_q <= 1'b0;
      len_q  <= '0;
      cnt_q  <= '0;
      key_q  <= '0;
      pos_q  <= '0;
      link_q <= 1'b1;
      max_q  <= wsfd_pkg::MAX_PAYLOAD_RST;
    end else begin
      ph_q   <= ph_d;
      op_q   <= op_d;
      mask_q <= mask_d;
      len_q  <= len_d;
      cnt_q  <= cnt_d;
      key_q  <= key_d;
      pos_q  <= pos_d;
      link_q <= link_d;
      if (cfg.valid) begin
        max_q <= cfg.max_payload;
      end
    end
  end

  a_link_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !link_q |=> !link_q) else $error("link reopened without reset");

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> (rx.valid && rx.ready && link_q))
    else $error("result without an accepted word");

  a_close_ends_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && push_res_o.frame_kind == wsfd_pkg::KIND_CLOSE) |=> !link_q)
    else $error("close or error result left link open");

  a_data_only_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && push_res_o.has_data) |-> (ph_q == PH_PAYLOAD))
    else $error("data byte outside payload");

endmodule

[sv/wsfd_skid.sv]
`timescale 1ns / 1ps

module wsfd_skid (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  wsfd_pkg::res_t  push_res_i,
  output logic            space_o,
  wsfd_res_if.source      res
);

  logic           main_v_q, main_v_d;
  logic           spare_v_q, spare_v_d;
  wsfd_pkg::res_t main_q, main_d;
  wsfd_pkg::res_t spare_q, spare_d;
  logic           pop;

  // registered ready: room is guaranteed while the spare slot is empty
  assign space_o = !spare_v_q;
  assign pop     = main_v_q && res.ready;

  always_comb begin
    main_v_d  = main_v_q;
    spare_v_d = spare_v_q;
    main_d    = main_q;
    spare_d   = spare_q;
    if (pop) begin
      if (spare_v_q) begin
        main_d    = spare_q;
        spare_v_d = 1'b0;
      end else begin
        main_v_d = 1'b0;
      end
    end
    if (push_valid_i) begin
      if (!main_v_d) begin
        main_d   = push_res_i;
        main_v_d = 1'b1;
      end else begin
        spare_d   = push_res_i;
        spare_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q  <= 1'b0;
      spare_v_q <= 1'b0;
    end else begin
      main_v_q  <= main_v_d;
      spare_v_q <= spare_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q  <= main_d;
    spare_q <= spare_d;
  end

  assign res.valid      = main_v_q;
  assign res.data_byte  = main_q.data_byte;
  assign res.has_data   = main_q.has_data;
  assign res.frame_kind = main_q.frame_kind;
  assign res.last       = main_q.last;
  assign res.status     = main_q.status;

  a_spare_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q |-> main_v_q) else $error("spare slot filled ahead of main");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_i |-> !spare_v_q) else $error("push into full skid");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !spare_v_q && !push_valid_i) |=> !main_v_q)
    else $error("word repeated after pop");

endmodule

[sv/websocket_frame_deframer.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Word
// rx_i     in   valid/ready        rx_byte[7:0], one received stream byte
// cfg_i    in   valid/ready        max_payload[31:0], always ready
// res_o    out  valid/ready        data_byte, has_data, frame_kind, last, status
//
// One byte per clock while res_o keeps up; each result is registered before res_o.
// Parse state lives in the parser registers; each byte's work is one pass of
// combinational logic into a two-entry output skid buffer.
// rx_i.ready comes straight from a flop (skid spare slot empty), so a stall on
// res_o lets through at most one more result word before rx_i backs up;
// header bytes that raise no result keep flowing until then.
// Async active-low reset: header phase, link open, max_payload = 1 MiB.

module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsfd_rx_if.sink     rx_i,
  wsfd_cfg_if.sink    cfg_i,
  wsfd_res_if.source  res_o
);

  logic           space;
  logic           push_valid;
  wsfd_pkg::res_t push_res;

  // header / length / key / payload parser; owns the limit register
  wsfd_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx           (rx_i),
    .cfg          (cfg_i),
    .space_i      (space),
    .push_valid_o (push_valid),
    .push_res_o   (push_res)
  );

  // result register with skid slot; decouples res_o.ready from rx_i.ready
  wsfd_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_res_i   (push_res),
    .space_o      (space),
    .res          (res_o)
  );

  a_empty_has_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.has_data) |-> res_o.last)
    else $error("empty result not marked last");

  a_error_is_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status) |-> (res_o.frame_kind == 2'(wsfd_pkg::KIND_CLOSE)))
    else $error("error result with wrong kind");

  a_close_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_kind == 2'(wsfd_pkg::KIND_CLOSE)) |-> !res_o.has_data)
    else $error("close result carries data");

endmodule

[tb/websocket_frame_deframer_test.sv]
`timescale 1ns / 1ps

module websocket_frame_deframer_test;

  localparam int          ITEMS       = 1800;
  localparam int          PHASE_BYTES = 220;
  localparam int          STALL_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 150;
  localparam int          BODY_CAP    = 400;
  localparam logic [3:0]  OP_PONG     = 4'hA;

  typedef enum logic [2:0] {
    P_HDR0,
    P_HDR1,
    P_EXTLEN,
    P_KEY,
    P_BODY
  } parse_e;

  typedef enum int {
    FORM_SHORT,
    FORM_16,
    FORM_64
  } len_form_e;

  // Tracks the parser state of the block and keeps the words it owes us.
  class deframe_scoreboard;
    wsfd_pkg::res_t pending_words[$];
    int             fails;
    logic [31:0]    limit;
    parse_e         ph;
    logic [3:0]     op;
    logic           masked;
    logic [63:0]    len;
    logic [2:0]     cnt;
    logic [31:0]    key;
    logic [31:0]    pos;
    logic           open;

    function new();
      fails  = 0;
      limit  = wsfd_pkg::MAX_PAYLOAD_RST;
      ph     = P_HDR0;
      op     = '0;
      masked = 1'b0;
      len    = '0;
      cnt    = '0;
      key    = '0;
      pos    = '0;
      open   = 1'b1;
    endfunction

    function void set_limit(logic [31:0] v);
      limit = v;
    endfunction

    function bit frame_done(output wsfd_pkg::res_t r);
      r       = '0;
      r.last  = 1'b1;
      ph      = P_HDR0;
      if (op == wsfd_pkg::OP_TEXT) begin
        r.frame_kind = wsfd_pkg::KIND_TEXT;
        return 1'b1;
      end
      if (op == wsfd_pkg::OP_PING) begin
        r.frame_kind = wsfd_pkg::KIND_PING;
        return 1'b1;
      end
      if (op == wsfd_pkg::OP_CLOSE) begin
        open         = 1'b0;
        r.frame_kind = wsfd_pkg::KIND_CLOSE;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit body_start(output wsfd_pkg::res_t r);
      r   = '0;
      pos = '0;
      if (len == 0)
        return frame_done(r);
      ph = P_BODY;
      return 1'b0;
    endfunction

    // Length is complete: limit check comes before any mask key
    function bit length_done(output wsfd_pkg::res_t r);
      r = '0;
      if (len > 64'(limit)) begin
        open         = 1'b0;
        r.frame_kind = wsfd_pkg::KIND_CLOSE;
        r.last       = 1'b1;
        r.status     = 1'b1;
        return 1'b1;
      end
      key = '0;
      if (masked) begin
        cnt = wsfd_pkg::KEY_CNT;
        ph  = P_KEY;
        return 1'b0;
      end
      return body_start(r);
    endfunction

    function bit parse_byte(logic [7:0] b, output wsfd_pkg::res_t r);
      int   sel;
      logic fin;
      r = '0;
      if (!open)
        return 1'b0;
      case (ph)
        P_HDR0: begin
          op = b[3:0];
          ph = P_HDR1;
          return 1'b0;
        end
        P_HDR1: begin
          masked = b[7];
          len    = '0;
          if (b[6:0] == wsfd_pkg::LEN_EXT16) begin
            cnt = wsfd_pkg::EXT16_CNT;
            ph  = P_EXTLEN;
            return 1'b0;
          end
          if (b[6:0] == wsfd_pkg::LEN_EXT64) begin
            cnt = wsfd_pkg::EXT64_CNT;
            ph  = P_EXTLEN;
            return 1'b0;
          end
          len = 64'(b[6:0]);
          return length_done(r);
        end
        P_EXTLEN: begin
          len = {len[55:0], b};
          if (cnt == 0)
            return length_done(r);
          cnt = cnt - 1'b1;
          return 1'b0;
        end
        P_KEY: begin
          key = {key[23:0], b};
          if (cnt == 0)
            return body_start(r);
          cnt = cnt - 1'b1;
          return 1'b0;
        end
        P_BODY: begin
          sel = 3 - int'(pos[1:0]);
          fin = (64'(pos) + 64'd1) >= len;
          pos = pos + 1;
          if (op == wsfd_pkg::OP_TEXT || op == wsfd_pkg::OP_PING) begin
            if (fin)
              ph = P_HDR0;
            r.data_byte  = b ^ key[8*sel +: 8];
            r.has_data   = 1'b1;
            r.frame_kind = (op == wsfd_pkg::OP_PING) ? wsfd_pkg::KIND_PING
                                                     : wsfd_pkg::KIND_TEXT;
            r.last       = fin;
            return 1'b1;
          end
          if (fin)
            return frame_done(r);
          return 1'b0;
        end
        default: begin
          ph = P_HDR0;
          return 1'b0;
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      wsfd_pkg::res_t r;
      if (parse_byte(b, r))
        pending_words.push_back(r);
    endfunction

    function void check_result(wsfd_pkg::res_t got);
      wsfd_pkg::res_t exp;
      if (pending_words.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected word: data %02h has %0b kind %0d last %0b status %0b",
                   got.data_byte, got.has_data, got.frame_kind, got.last, got.status);
        return;
      end
      exp = pending_words.pop_front();
      if (got.data_byte !== exp.data_byte || got.has_data !== exp.has_data ||
          got.frame_kind !== exp.frame_kind || got.last !== exp.last ||
          got.status !== exp.status) begin
        fails++;
        if (fails <= 10) begin
          $display("word mismatch: exp data %02h has %0b kind %0d last %0b status %0b",
                   exp.data_byte, exp.has_data, exp.frame_kind, exp.last, exp.status);
          $display("               got data %02h has %0b kind %0d last %0b status %0b",
                   got.data_byte, got.has_data, got.frame_kind, got.last, got.status);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;       // no idling on either side while set
  bit   squeeze_req;  // asks the result side for one long hold-off
  int   sent;

  deframe_scoreboard sb = new();

  wsfd_rx_if  rx_bus ();
  wsfd_cfg_if cfg_bus ();
  wsfd_res_if res_bus ();

  websocket_frame_deframer uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_bus),
    .cfg_i  (cfg_bus),
    .res_o  (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one stream byte, with random gaps, and wait for it to be taken
  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 31) begin
      rx_bus.valid = 1'b0;
      @(negedge clk);
    end
    rx_bus.valid   = 1'b1;
    rx_bus.rx_byte = b;
    do
      @(posedge clk);
    while (!rx_bus.ready);
    sb.note_byte(b);
    sent++;
  endtask

  // Header, length in the chosen form, optional key, then nbody random bytes
  task automatic send_frame(logic [3:0] op, logic [63:0] n, bit masked, len_form_e form,
                            int nbody);
    logic [31:0] k;
    k = $urandom;
    send_byte({4'($urandom), op});
    case (form)
      FORM_SHORT: send_byte({masked, n[6:0]});
      FORM_16: begin
        send_byte({masked, wsfd_pkg::LEN_EXT16});
        send_byte(n[15:8]);
        send_byte(n[7:0]);
      end
      default: begin
        send_byte({masked, wsfd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--)
          send_byte(n[8*i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--)
        send_byte(k[8*i +: 8]);
    for (int i = 0; i < nbody; i++)
      send_byte(8'($urandom));
  endtask

  // Short lengths mostly take the 7-bit form, but the longer forms may carry them too
  function automatic len_form_e pick_form(logic [63:0] n);
    int r;
    r = $urandom_range(99);
    if (n <= 125)
      return (r < 70) ? FORM_SHORT : ((r < 90) ? FORM_16 : FORM_64);
    if (n < 65536)
      return (r < 80) ? FORM_16 : FORM_64;
    return FORM_64;
  endfunction

  // Any frame that keeps the link open under the given limit
  task automatic random_frame(logic [31:0] lim);
    logic [3:0] op;
    int         cap;
    int         n;
    int         r;
    cap = (lim > BODY_CAP) ? BODY_CAP : int'(lim);
    r   = $urandom_range(99);
    if (r < 45)
      op = wsfd_pkg::OP_TEXT;
    else if (r < 70)
      op = wsfd_pkg::OP_PING;
    else if (r < 80)
      op = OP_PONG;
    else begin
      do
        op = 4'($urandom);
      while (op == wsfd_pkg::OP_CLOSE);
    end
    r = $urandom_range(99);
    if (r < 45)
      n = $urandom_range((cap < 8) ? cap : 8);
    else if (r < 70)
      n = $urandom_range((cap < 125) ? cap : 125);
    else if (r < 82)
      n = (cap >= 126) ? $urandom_range(cap, 126) : $urandom_range(cap);
    else if (r < 90)
      n = cap;  // right on the limit, or on BODY_CAP when that is lower
    else
      n = 0;
    send_frame(op, 64'(n), 1'($urandom), pick_form(64'(n)), n);
  endtask

  // Stop offering, let every owed word arrive, then allow for frames that owe none
  task automatic drain(int settle);
    @(negedge clk);
    rx_bus.valid = 1'b0;
    while (sb.pending_words.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    drain(8);
    @(negedge clk);
    cfg_bus.valid       = 1'b1;
    cfg_bus.max_payload = v;
    do
      @(posedge clk);
    while (!cfg_bus.ready);
    sb.set_limit(v);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Result side: random back-pressure plus one long hold-off on request
  initial begin
    int hold;
    hold          = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        hold        = HOLD_CYCLES;
        squeeze_req = 1'b0;
      end
      if (hold > 0) begin
        res_bus.ready = 1'b0;
        hold--;
      end else begin
        res_bus.ready = steady || ($urandom_range(99) >= 31);
      end
    end
  end

  initial begin
    wsfd_pkg::res_t got;
    forever begin
      @(posedge clk);
      if (rst_n && res_bus.valid && res_bus.ready) begin
        got.data_byte  = res_bus.data_byte;
        got.has_data   = res_bus.has_data;
        got.frame_kind = wsfd_pkg::kind_e'(res_bus.frame_kind);
        got.last       = res_bus.last;
        got.status     = res_bus.status;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: too long without any word moving on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          p;
    int          mark;
    logic [31:0] lim;
    logic [63:0] n;
    logic [3:0]  op;
    rst_n               = 1'b0;
    steady              = 1'b0;
    squeeze_req         = 1'b0;
    sent                = 0;
    rx_bus.valid        = 1'b0;
    rx_bus.rx_byte      = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.max_payload = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed frames under the reset limit: empty text, masked ping,
    // 16-bit length text, pong and an unknown opcode with a 64-bit length
    send_frame(wsfd_pkg::OP_TEXT, 64'd0, 1'b0, FORM_SHORT, 0);
    send_frame(wsfd_pkg::OP_PING, 64'd2, 1'b1, FORM_SHORT, 2);
    send_frame(wsfd_pkg::OP_TEXT, 64'd1, 1'b0, FORM_16, 1);
    send_frame(OP_PONG, 64'd1, 1'b0, FORM_SHORT, 1);
    send_frame(4'hF, 64'd0, 1'b0, FORM_64, 0);

    lim = wsfd_pkg::MAX_PAYLOAD_RST;
    p   = 0;
    while (sent < ITEMS) begin
      p++;
      case (p)
        1:       lim = 32'd0;
        2:       lim = '1;
        3:       lim = 32'd1;
        4:       lim = 32'd65535;
        5:       lim = 32'd125;
        6:       lim = 32'd126;
        7:       lim = $urandom_range(BODY_CAP, 2);
        8:       lim = '1;
        default: lim = $urandom_range(1) ? 32'($urandom_range(600)) : 32'($urandom);
      endcase
      write_limit(lim);
      steady = (p == 3);
      if (p == 4)
        squeeze_req = 1'b1;
      mark = sent;
      while (sent - mark < PHASE_BYTES)
        random_frame(lim);
    end
    steady = 1'b0;

    // Closing frame or an over-limit length ends the link; trailing bytes must vanish
    if ($urandom_range(1)) begin
      n = 64'($urandom_range((lim < 6) ? int'(lim) : 6));
      send_frame(wsfd_pkg::OP_CLOSE, n, 1'($urandom), pick_form(n), int'(n));
    end else begin
      if (lim == '1 || $urandom_range(1))
        n = {8'($urandom_range(255, 1)), 24'($urandom), 32'($urandom)};
      else
        n = 64'(lim) + 64'd1;
      op = $urandom_range(1) ? wsfd_pkg::OP_PING : wsfd_pkg::OP_TEXT;
      send_frame(op, n, 1'($urandom), pick_form(n), 3);
    end
    repeat (16) send_byte(8'($urandom));

    drain(20);
    if (sb.fails == 0 && sb.pending_words.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
